### hdl/tmtw_pkg.sv
`default_nettype none

package tmtw_pkg;

   // screen geometry
   localparam int SCREEN_COLUMNS = 80;
   localparam int SCREEN_ROWS    = 25;
   localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;
   localparam int ADDR_W         = $clog2(CELL_COUNT);

   // field widths
   localparam int ROW_W       = 5;
   localparam int COL_W       = 7;
   localparam int CELL_W      = 16;
   localparam int ATTR_W      = 8;
   localparam int CHAR_W      = 8;
   localparam int LINES_W     = 5;
   localparam int TAB_W       = 7;
   localparam int FUNC_W      = 2;
   localparam int INDEX_W     = 11;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;

   // item function codes
   localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_SCROLL = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_TEXT_ATTRIBUTE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAB_WIDTH      = 1'd1;

   // character codes and cell values
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_BLANK   = 8'h20;
   localparam logic [CELL_W-1:0] RESET_CELL   = 16'h0720;
   localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;
   localparam logic [TAB_W-1:0]  RESET_TAB    = 7'd15;

   typedef logic [ADDR_W-1:0] cell_addr_type;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [CHAR_W-1:0]  char_code;
      logic [LINES_W-1:0] scroll_lines;
      logic [INDEX_W-1:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [ROW_W-1:0]  cursor_row_out;
      logic [COL_W-1:0]  cursor_col_out;
      logic [CELL_W-1:0] cell_data;
      logic              scrolled;
   } rsp_type;

   // write port of the cell store
   typedef struct packed {
      logic              en;
      cell_addr_type     addr;
      logic [CELL_W-1:0] data;
   } cell_wr_type;

endpackage

`default_nettype wire

### hdl/text_mode_terminal_writer.sv
`default_nettype none

// channel  | ports                              | direction | moves
// ---------+------------------------------------+-----------+--------------------------
// request  | req_valid req_ready req_data       | in        | one item word per accept
// response | rsp_valid rsp_ready rsp_data       | out       | one result word per item
// csr      | csr_valid csr_ready csr_index/data | in        | one register write
//
// after reset a clearing pass writes the blank cell to all 2000 cells,
// req_ready stays low meanwhile; csr writes are taken at any time
// a printable byte is written, then one cursor advance; a tab makes tabw_ff advances
// a scroll walks the whole cell store once, one cell per cycle on the single write
// port, for every scroll, also one that starts inside a tab
// one item at a time; the result waits in an output register while the next word runs

module text_mode_terminal_writer (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  tmtw_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output tmtw_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tmtw_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [tmtw_pkg::CSR_DATA_W-1:0]       csr_data
);
   import tmtw_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_ADVANCE,
      ST_COPY,
      ST_FILL,
      ST_READ_WAIT,
      ST_FINISH
   } state_type;

   state_type         state_ff, state_in;
   state_type         ret_ff, ret_in;        // where a scroll returns to
   req_type           item_ff, item_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [TAB_W-1:0]  steps_ff, steps_in;    // cursor advances still to do
   logic              scrolled_ff, scrolled_in;
   logic [CELL_W-1:0] data_ff, data_in;
   logic [ATTR_W-1:0] attr_ff, attr_in;
   logic [TAB_W-1:0]  tabw_ff, tabw_in;
   cell_addr_type     src_ff, src_in;        // copy source
   cell_addr_type     dst_ff, dst_in;        // copy, fill and clear target
   cell_addr_type     keep_ff, keep_in;      // cells kept by a scroll
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // pending write, registered before it reaches the cell store
   logic              wr_en_ff, wr_en_in;
   logic              wr_copy_ff, wr_copy_in;
   cell_addr_type     wr_addr_ff, wr_addr_in;
   logic [CELL_W-1:0] wr_data_ff, wr_data_in;

   cell_wr_type       store_wr;
   logic              rd_en;
   cell_addr_type     rd_addr;
   logic [CELL_W-1:0] rd_data;

   // scroll start
   logic              start_scroll;
   logic [LINES_W-1:0] scroll_n;
   cell_addr_type     scroll_from;
   cell_addr_type     scroll_keep;
   state_type         scroll_ret;

   cell_addr_type     cursor_pos;
   logic              item_accept;

   assign item_accept = req_valid && req_ready;
   assign req_ready   = (state_ff == ST_IDLE);
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_ff;

   assign cursor_pos  = ADDR_W'(row_ff) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(col_ff);
   assign scroll_from = ADDR_W'(scroll_n) * ADDR_W'(SCREEN_COLUMNS);
   assign scroll_keep = ADDR_W'(CELL_COUNT) - scroll_from;

   // copy writes take the word read in the cycle before
   assign store_wr.en   = wr_en_ff;
   assign store_wr.addr = wr_addr_ff;
   assign store_wr.data = wr_copy_ff ? rd_data : wr_data_ff;

   tmtw_cell_store u_cells (
      .clock   (clock),
      .wr      (store_wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      item_in      = item_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      steps_in     = steps_ff;
      scrolled_in  = scrolled_ff;
      data_in      = data_ff;
      attr_in      = attr_ff;
      tabw_in      = tabw_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      keep_in      = keep_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      wr_en_in     = 1'b0;
      wr_copy_in   = 1'b0;
      wr_addr_in   = dst_ff;
      wr_data_in   = wr_data_ff;
      rd_en        = 1'b0;
      rd_addr      = src_ff;
      start_scroll = 1'b0;
      scroll_n     = LINES_W'(1);
      scroll_ret   = ST_FINISH;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         unique case (csr_index)
            CSR_TEXT_ATTRIBUTE: attr_in = csr_data;
            CSR_TAB_WIDTH:      tabw_in = csr_data[TAB_W-1:0];
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            // blank every cell once after reset
            wr_en_in   = 1'b1;
            wr_addr_in = dst_ff;
            wr_data_in = RESET_CELL;
            dst_in     = dst_ff + 1'b1;
            if (dst_ff == ADDR_W'(CELL_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (item_accept) begin
               item_in  = req_data;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            scrolled_in = 1'b0;
            data_in     = '0;
            state_in    = ST_FINISH;
            case (item_ff.func)
               FUNC_WRITE: begin
                  if (item_ff.char_code == CHAR_NEWLINE) begin
                     col_in = '0;
                     if (row_ff == ROW_W'(SCREEN_ROWS - 1)) begin
                        start_scroll = 1'b1;
                     end else begin
                        row_in = row_ff + 1'b1;
                     end
                  end else if (item_ff.char_code == CHAR_TAB) begin
                     steps_in = tabw_ff;
                     if (tabw_ff != '0) begin
                        state_in = ST_ADVANCE;
                     end
                  end else begin
                     // print at the cursor, then one advance
                     wr_en_in   = 1'b1;
                     wr_addr_in = cursor_pos;
                     wr_data_in = {attr_ff, item_ff.char_code};
                     steps_in   = TAB_W'(1);
                     state_in   = ST_ADVANCE;
                  end
               end
               FUNC_SCROLL: begin
                  if (item_ff.scroll_lines != '0 &&
                      item_ff.scroll_lines <= LINES_W'(SCREEN_ROWS)) begin
                     start_scroll = 1'b1;
                     scroll_n     = item_ff.scroll_lines;
                  end
               end
               FUNC_READ: begin
                  if (item_ff.cell_index < INDEX_W'(CELL_COUNT)) begin
                     rd_en    = 1'b1;
                     rd_addr  = item_ff.cell_index[ADDR_W-1:0];
                     state_in = ST_READ_WAIT;
                  end
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_ADVANCE: begin
            // one cursor step per cycle, paused while a scroll runs
            steps_in = steps_ff - 1'b1;
            state_in = (steps_ff == TAB_W'(1)) ? ST_FINISH : ST_ADVANCE;
            if (col_ff == COL_W'(SCREEN_COLUMNS - 1)) begin
               col_in = '0;
               if (row_ff == ROW_W'(SCREEN_ROWS - 1)) begin
                  start_scroll = 1'b1;
                  scroll_ret   = (steps_ff == TAB_W'(1)) ? ST_FINISH : ST_ADVANCE;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         ST_COPY: begin
            // read ahead at the source; the registered write takes the word read here
            rd_en      = 1'b1;
            rd_addr    = src_ff;
            wr_en_in   = 1'b1;
            wr_copy_in = 1'b1;
            wr_addr_in = dst_ff;
            src_in     = src_ff + 1'b1;
            dst_in     = dst_ff + 1'b1;
            if (dst_ff == keep_ff - 1'b1) begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            // vacated rows get blanks in the current attribute
            wr_en_in   = 1'b1;
            wr_addr_in = dst_ff;
            wr_data_in = {attr_ff, CHAR_BLANK};
            dst_in     = dst_ff + 1'b1;
            if (dst_ff == ADDR_W'(CELL_COUNT - 1)) begin
               state_in = ret_ff;
            end
         end
         ST_READ_WAIT: begin
            data_in  = rd_data;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.cursor_row_out = row_ff;
               rsp_in.cursor_col_out = col_ff;
               rsp_in.cell_data      = data_ff;
               rsp_in.scrolled       = scrolled_ff;
               rsp_valid_in          = 1'b1;
               state_in              = ST_IDLE;
            end
         end
      endcase

      if (start_scroll) begin
         src_in      = scroll_from;
         dst_in      = '0;
         keep_in     = scroll_keep;
         ret_in      = scroll_ret;
         row_in      = ROW_W'(SCREEN_ROWS - 1);
         scrolled_in = 1'b1;
         state_in    = (scroll_keep == '0) ? ST_FILL : ST_COPY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ret_ff       <= ST_FINISH;
         row_ff       <= '0;
         col_ff       <= '0;
         steps_ff     <= '0;
         attr_ff      <= RESET_ATTR;
         tabw_ff      <= RESET_TAB;
         dst_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         wr_en_ff     <= 1'b0;
         wr_copy_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         steps_ff     <= steps_in;
         attr_ff      <= attr_in;
         tabw_ff      <= tabw_in;
         dst_ff       <= dst_in;
         rsp_valid_ff <= rsp_valid_in;
         wr_en_ff     <= wr_en_in;
         wr_copy_ff   <= wr_copy_in;
      end
      item_ff     <= item_in;
      scrolled_ff <= scrolled_in;
      data_ff     <= data_in;
      src_ff      <= src_in;
      keep_ff     <= keep_in;
      rsp_ff      <= rsp_in;
      wr_addr_ff  <= wr_addr_in;
      wr_data_ff  <= wr_data_in;
   end

endmodule

`default_nettype wire

### hdl/tmtw_cell_store.sv
`default_nettype none

module tmtw_cell_store (
   input  logic                            clock,
   input  tmtw_pkg::cell_wr_type           wr,
   input  logic                            rd_en,
   input  tmtw_pkg::cell_addr_type         rd_addr,
   output logic [tmtw_pkg::CELL_W-1:0]     rd_data
);
   import tmtw_pkg::*;

   logic [CELL_W-1:0] cells_ff [CELL_COUNT];
   logic [CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         cells_ff[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= cells_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
